>>> rtl/srv_pkg.sv
// Shared types, constants and the CRC byte update for the settings record validator.
package srv_pkg;

   localparam logic [15:0] CURRENT_MAGIC  = 16'h8A6F;
   localparam logic [15:0] RESET_MAGIC    = 16'hA551;
   localparam logic [7:0]  END_MARKER     = 8'hE5;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;
   localparam logic [14:0] CURRENT_FORMAT = 15'd1;
   localparam logic [15:0] MIN_LENGTH     = 16'd9;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_MAGIC  = 3'd1,
      ST_TOO_LONG   = 3'd2,
      ST_FUTURE_FMT = 3'd3,
      ST_FORMAT_0   = 3'd4,
      ST_BAD_MARKER = 3'd5,
      ST_BAD_CRC    = 3'd6,
      ST_TOO_SHORT  = 3'd7
   } status_type;

   // one classified input word as queued between front and back
   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic [7:0] index;
   } item_type;

   typedef struct packed {
      status_type status;
      logic       format_number;
      logic       alarm_variant;
      logic [7:0] record_length;
   } result_type;

   // reflected CRC-16, one byte, bitwise
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else c = c >> 1;
      end
      return c;
   endfunction

endpackage

>>> rtl/srv_front.sv
// Front end: accepts record bytes and tags each with its position in the record.
module srv_front import srv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tuser,
   input  logic       q_ready,
   output logic       q_valid,
   output item_type   q_item
);

   logic [7:0] index_ff, index_in;
   logic [7:0] cur_index;
   logic       accept;

   assign req_tready = q_ready;
   assign q_valid    = req_tvalid;
   assign accept     = req_tvalid & q_ready;

   assign cur_index = req_tuser ? 8'd0 : index_ff;

   // saturate: a record is judged well before the count could wrap
   assign index_in = (cur_index == 8'hFF) ? cur_index : cur_index + 8'd1;

   assign q_item = '{data: req_tdata, first: req_tuser, index: cur_index};

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 8'd0;
      end else if (accept) begin
         index_ff <= index_in;
      end
   end

endmodule

>>> rtl/srv_queue.sv
// Two-entry queue between the front and the back.
module srv_queue import srv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_ready,
   input  item_type wr_item,
   output logic     rd_valid,
   input  logic     rd_ready,
   output item_type rd_item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_item  = entry_ff[rd_ptr_ff];
   assign push     = wr_valid & wr_ready;
   assign pop      = rd_valid & rd_ready;

   always_comb begin
      count_in = count_ff;
      if (push & ~pop) count_in = count_ff + 2'd1;
      else if (pop & ~push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= wr_item;
   end

endmodule

>>> rtl/srv_back.sv
// Back end: header parse, CRC, marker and length checks, result register.
module srv_back import srv_pkg::*; #(
   parameter int LEGACY_LENGTH = 64,
   parameter int MAX_LENGTH    = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] legacy_magic,
   input  logic        q_valid,
   output logic        q_ready,
   input  item_type    q_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output result_type  rsp_result
);

   logic [15:0] crc_ff, crc_in, crc_cur, crc_upd;
   logic [7:0]  hdr_ff, hdr_in, hdr_cur;
   logic [15:0] fmtw_ff, fmtw_in, fmtw_cur;
   logic [7:0]  len_ff, len_in, len_cur;
   logic [7:0]  scl_ff, scl_in, scl_cur;
   logic        judged_ff, judged_in, judged_cur;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  res_ff, res;
   logic        emit, pop;
   logic [15:0] word;
   logic [7:0]  shown;
   logic        fmt_bit, alarm;

   assign q_ready    = ~rsp_valid_ff | rsp_ready;
   assign pop        = q_valid & q_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = res_ff;

   always_comb begin
      crc_cur    = q_item.first ? CRC_INIT : crc_ff;
      hdr_cur    = q_item.first ? 8'd0 : hdr_ff;
      fmtw_cur   = q_item.first ? 16'd0 : fmtw_ff;
      len_cur    = q_item.first ? 8'd0 : len_ff;
      scl_cur    = q_item.first ? 8'd0 : scl_ff;
      judged_cur = q_item.first ? 1'b0 : judged_ff;

      crc_in    = crc_cur;
      hdr_in    = hdr_cur;
      fmtw_in   = fmtw_cur;
      len_in    = len_cur;
      scl_in    = scl_cur;
      emit      = 1'b0;
      crc_upd   = crc_byte(crc_cur, q_item.data);
      word      = {q_item.data, hdr_cur};
      shown     = (word[15:8] != 8'd0) ? 8'hFF : word[7:0];
      fmt_bit   = (fmtw_cur != 16'd0);
      alarm     = fmtw_cur[15];
      res       = '{status: ST_OK, format_number: fmt_bit, alarm_variant: alarm,
                    record_length: len_cur};

      if (!judged_cur) begin
         if (q_item.index < 8'd2) begin
            crc_in = crc_upd;
            if (q_item.index == 8'd0) begin
               hdr_in = q_item.data;
            end else if (word == legacy_magic) begin
               fmtw_in = 16'd0;
               len_in  = 8'(LEGACY_LENGTH);
            end else if (word == CURRENT_MAGIC) begin
               fmtw_in = 16'd0;
               len_in  = 8'd0;
            end else begin
               emit = 1'b1;
               res  = '{status: ST_BAD_MAGIC, format_number: 1'b0, alarm_variant: 1'b0,
                        record_length: 8'd0};
            end
         end else if (len_cur == 8'd0) begin
            // current-format header words, bytes 2..5
            crc_in = crc_upd;
            res.format_number = 1'b1;
            res.record_length = shown;
            unique case (q_item.index)
               8'd2, 8'd4: hdr_in  = q_item.data;
               8'd3:       fmtw_in = word;
               default: begin
                  emit = 1'b1;
                  priority if (word > 16'(MAX_LENGTH)) res.status = ST_TOO_LONG;
                  else if (fmtw_cur[14:0] > CURRENT_FORMAT) res.status = ST_FUTURE_FMT;
                  else if (fmtw_cur[14:0] == 15'd0) res.status = ST_FORMAT_0;
                  else if (word < MIN_LENGTH) res.status = ST_TOO_SHORT;
                  else begin
                     emit   = 1'b0;
                     len_in = word[7:0];
                  end
               end
            endcase
         end else begin
            if (q_item.index == len_cur - 8'd3 && q_item.data != END_MARKER) begin
               emit = 1'b1;
               res.status = ST_BAD_MARKER;
            end else if (q_item.index < len_cur - 8'd2) begin
               crc_in = crc_upd;
            end else if (q_item.index == len_cur - 8'd2) begin
               scl_in = q_item.data;
            end else begin
               emit = 1'b1;
               res.status = ({q_item.data, scl_cur} == crc_cur) ? ST_OK : ST_BAD_CRC;
            end
         end
      end
      judged_in = judged_cur | emit;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         hdr_ff       <= 8'd0;
         fmtw_ff      <= 16'd0;
         len_ff       <= 8'd0;
         scl_ff       <= 8'd0;
         judged_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            crc_ff    <= crc_in;
            hdr_ff    <= hdr_in;
            fmtw_ff   <= fmtw_in;
            len_ff    <= len_in;
            scl_ff    <= scl_in;
            judged_ff <= judged_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) res_ff <= res;
   end

endmodule

>>> rtl/settings_record_validator.sv
// Settings record validator: a record streams in one byte a word, tuser marks byte zero.
// The 16-bit start magic selects legacy (fixed length, format 0) or current format
// (format and length words follow); the end marker and a reflected CRC-16 (0xA001,
// init 0xFFFF) over every byte ahead of the CRC are checked, and one status word is
// sent per record. Later bytes are dropped until the next first byte. Throughput is
// one byte per clock while no status word waits: the CRC byte update and compares
// are combinational in the back end. The deciding byte passes a queue entry, then
// the status word is registered. While a status word waits on rsp_tready the two-entry
// queue takes two more bytes, then req_tready drops until the word is taken.
module settings_record_validator import srv_pkg::*; #(
   parameter int LEGACY_LENGTH = 64,
   parameter int MAX_LENGTH    = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] record_byte
   input  logic        req_tuser,   // [0] first_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] status, [3] format_number,
                                    // [4] alarm_variant, [12:5] record_length
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // legacy_magic
);

   logic [15:0] legacy_magic_ff;
   logic        f_valid, f_ready, b_valid, b_ready;
   item_type    f_item, b_item;
   result_type  result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         legacy_magic_ff <= RESET_MAGIC;
      end else if (csr_valid) begin
         legacy_magic_ff <= csr_data;
      end
   end

   srv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (f_ready),
      .q_valid    (f_valid),
      .q_item     (f_item)
   );

   srv_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_item  (f_item),
      .rd_valid (b_valid),
      .rd_ready (b_ready),
      .rd_item  (b_item)
   );

   srv_back #(
      .LEGACY_LENGTH (LEGACY_LENGTH),
      .MAX_LENGTH    (MAX_LENGTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .legacy_magic (legacy_magic_ff),
      .q_valid      (b_valid),
      .q_ready      (b_ready),
      .q_item       (b_item),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_result   (result)
   );

   assign rsp_tdata = {3'b000, result.record_length, result.alarm_variant,
                       result.format_number, result.status};

endmodule
